### design/xxh_pkg.sv
// shared word type and prime constants for the xxh64 stream hash
`timescale 1ns / 1ps
`default_nettype none

package xxh_pkg;

    typedef logic [63:0] word_t;

    localparam word_t PRIME1 = 64'h9E37_79B1_85EB_CA87;
    localparam word_t PRIME2 = 64'hC2B2_AE3D_27D4_EB4F;
    localparam word_t PRIME3 = 64'h1656_67B1_9E37_79F9;
    localparam word_t PRIME4 = 64'h85EB_CA77_C2B2_AE63;
    localparam word_t PRIME5 = 64'h27D4_EB2F_1656_67C5;

    function automatic word_t rotl64(input word_t x, input int unsigned r);
        word_t res;
        res = (x << r) | (x >> (64 - r));
        return res;
    endfunction

endpackage

`default_nettype wire

### design/xxh64_stream_hash.sv
// top level of the streaming 64-bit xxhash engine
//
// channel  direction  ports                                       beat
// s_       in         s_data_word, s_byte_count, s_last           one message word
// m_       out        m_hash                                      hash of one message
// cfg_     in         cfg_seed                                    seed write
//
// a word that does not complete a stripe is buffered
// a word that completes a stripe runs eight 64-bit products in turn,
// each on the single shared 32x32 multiplier
// the last word adds the tail and avalanche
// s_ready is low while a word or the finish is in work; a waiting hash stalls
// only the final output step; reset is synchronous and clears all control state
`timescale 1ns / 1ps
`default_nettype none

module xxh64_stream_hash (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire xxh_pkg::word_t s_data_word,
    input  wire logic [3:0]     s_byte_count,
    input  wire logic           s_last,
    output logic                m_valid,
    input  wire logic           m_ready,
    output xxh_pkg::word_t      m_hash,
    input  wire logic           cfg_valid,
    output logic                cfg_ready,
    input  wire xxh_pkg::word_t cfg_seed
);
    import xxh_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_R1    = 5'd1;
    localparam logic [4:0] ST_R2    = 5'd2;
    localparam logic [4:0] ST_BEGIN = 5'd3;
    localparam logic [4:0] ST_CONV  = 5'd4;
    localparam logic [4:0] ST_MRG1  = 5'd5;
    localparam logic [4:0] ST_MRG2  = 5'd6;
    localparam logic [4:0] ST_MRG3  = 5'd7;
    localparam logic [4:0] ST_LEN   = 5'd8;
    localparam logic [4:0] ST_TW1   = 5'd9;
    localparam logic [4:0] ST_TW2   = 5'd10;
    localparam logic [4:0] ST_TW3   = 5'd11;
    localparam logic [4:0] ST_H1    = 5'd12;
    localparam logic [4:0] ST_H2    = 5'd13;
    localparam logic [4:0] ST_B1    = 5'd14;
    localparam logic [4:0] ST_B2    = 5'd15;
    localparam logic [4:0] ST_AV1   = 5'd16;
    localparam logic [4:0] ST_AV2   = 5'd17;
    localparam logic [4:0] ST_OUT   = 5'd18;

    logic [4:0]  state_reg, state_next;
    logic        issued_reg, issued_next;
    logic [1:0]  idx_reg, idx_next;
    logic [1:0]  pend_cnt_reg, pend_cnt_next;
    word_t       total_reg, total_next;
    logic        stripe_reg, stripe_next;
    word_t       seed_reg;
    logic        m_valid_reg, m_valid_next;
    logic        last_reg, last_next;

    word_t       lane_reg [4];
    word_t       lane_next [4];
    word_t       pend_reg [3];
    word_t       pend_next [3];
    word_t       w_reg, w_next;
    word_t       h_reg, h_next;
    word_t       t_reg, t_next;
    logic [55:0] part_reg, part_next;
    logic [2:0]  nbytes_reg, nbytes_next;
    word_t       hash_reg, hash_next;

    logic        mul_start, mul_done, is_mul;
    word_t       mul_a, mul_b, mul_p;
    word_t       lane_sel, word_sel, conv_term;
    logic        s_accept, full_word, msg_start;
    logic [55:0] part_in;
    logic [4:0]  after_words, after_half;

    xxh_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign full_word = !s_last || s_byte_count[3];
    assign msg_start = (total_reg == '0) && !stripe_reg && (pend_cnt_reg == 2'd0);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_hash    = hash_reg;

    assign lane_sel = lane_reg[idx_reg];

    always_comb begin
        case (idx_reg)
            2'd0:    word_sel = pend_reg[0];
            2'd1:    word_sel = pend_reg[1];
            2'd2:    word_sel = pend_reg[2];
            default: word_sel = w_reg;
        endcase
    end

    always_comb begin
        case (idx_reg)
            2'd1:    conv_term = rotl64(lane_reg[1], 7);
            2'd2:    conv_term = rotl64(lane_reg[2], 12);
            2'd3:    conv_term = rotl64(lane_reg[3], 18);
            default: conv_term = rotl64(lane_reg[0], 1);
        endcase
    end

    // keep only the counted low bytes of a short last word
    always_comb begin
        for (int i = 0; i < 7; i++) begin
            part_in[8*i +: 8] = (3'(i) < s_byte_count[2:0]) ? s_data_word[8*i +: 8] : 8'd0;
        end
    end

    assign after_half  = (nbytes_reg != 3'd4) ? ST_B1 : ST_AV1;
    assign after_words = (nbytes_reg[2]) ? ST_H1 : ((nbytes_reg != 3'd0) ? ST_B1 : ST_AV1);

    // operand select for the shared multiplier
    always_comb begin
        is_mul = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_R1:   begin mul_a = word_sel;                  mul_b = PRIME2; end
            ST_R2:   begin mul_a = t_reg;                     mul_b = PRIME1; end
            ST_MRG1: begin mul_a = lane_sel;                  mul_b = PRIME2; end
            ST_MRG2: begin mul_a = t_reg;                     mul_b = PRIME1; end
            ST_MRG3: begin mul_a = h_reg;                     mul_b = PRIME1; end
            ST_TW1:  begin mul_a = word_sel;                  mul_b = PRIME2; end
            ST_TW2:  begin mul_a = t_reg;                     mul_b = PRIME1; end
            ST_TW3:  begin mul_a = rotl64(h_reg, 27);         mul_b = PRIME1; end
            ST_H1:   begin mul_a = {32'b0, part_reg[31:0]};   mul_b = PRIME1; end
            ST_H2:   begin mul_a = rotl64(h_reg, 23);         mul_b = PRIME2; end
            ST_B1:   begin mul_a = {56'b0, part_reg[7:0]};    mul_b = PRIME5; end
            ST_B2:   begin mul_a = rotl64(h_reg, 11);         mul_b = PRIME1; end
            ST_AV1:  begin mul_a = h_reg ^ (h_reg >> 33);     mul_b = PRIME2; end
            ST_AV2:  begin mul_a = h_reg ^ (h_reg >> 29);     mul_b = PRIME3; end
            default: is_mul = 1'b0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        issued_next   = issued_reg;
        idx_next      = idx_reg;
        pend_cnt_next = pend_cnt_reg;
        total_next    = total_reg;
        stripe_next   = stripe_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        last_next     = last_reg;
        lane_next     = lane_reg;
        pend_next     = pend_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        t_next        = t_reg;
        part_next     = part_reg;
        nbytes_next   = nbytes_reg;
        hash_next     = hash_reg;
        mul_start     = 1'b0;

        if (is_mul && !issued_reg) begin
            mul_start   = 1'b1;
            issued_next = 1'b1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    last_next = s_last;
                    if (msg_start) begin
                        lane_next[0] = seed_reg + PRIME1 + PRIME2;
                        lane_next[1] = seed_reg + PRIME2;
                        lane_next[2] = seed_reg;
                        lane_next[3] = seed_reg - PRIME1;
                    end
                    if (full_word) begin
                        total_next  = total_reg + 64'd8;
                        part_next   = '0;
                        nbytes_next = 3'd0;
                        if (pend_cnt_reg != 2'd3) begin
                            pend_next[pend_cnt_reg] = s_data_word;
                            pend_cnt_next = pend_cnt_reg + 2'd1;
                            state_next    = s_last ? ST_BEGIN : ST_IDLE;
                        end else begin
                            w_next     = s_data_word;
                            idx_next   = 2'd0;
                            state_next = ST_R1;
                        end
                    end else begin
                        total_next  = total_reg + {60'b0, s_byte_count};
                        part_next   = part_in;
                        nbytes_next = s_byte_count[2:0];
                        state_next  = ST_BEGIN;
                    end
                end
            end
            ST_R1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    t_next      = rotl64(lane_sel + mul_p, 31);
                    state_next  = ST_R2;
                end
            end
            ST_R2: begin
                if (mul_done) begin
                    issued_next        = 1'b0;
                    lane_next[idx_reg] = mul_p;
                    idx_next           = idx_reg + 2'd1;
                    state_next         = ST_R1;
                    if (idx_reg == 2'd3) begin
                        pend_cnt_next = 2'd0;
                        stripe_next   = 1'b1;
                        state_next    = last_reg ? ST_BEGIN : ST_IDLE;
                    end
                end
            end
            ST_BEGIN: begin
                idx_next = 2'd1;
                if (stripe_reg) begin
                    h_next     = conv_term;
                    state_next = ST_CONV;
                end else begin
                    h_next     = lane_reg[2] + PRIME5;
                    state_next = ST_LEN;
                end
            end
            ST_CONV: begin
                h_next   = h_reg + conv_term;
                idx_next = idx_reg + 2'd1;
                if (idx_reg == 2'd3) begin
                    state_next = ST_MRG1;
                end
            end
            ST_MRG1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    t_next      = rotl64(mul_p, 31);
                    state_next  = ST_MRG2;
                end
            end
            ST_MRG2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_p;
                    state_next  = ST_MRG3;
                end
            end
            ST_MRG3: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p + PRIME4;
                    idx_next    = idx_reg + 2'd1;
                    state_next  = (idx_reg == 2'd3) ? ST_LEN : ST_MRG1;
                end
            end
            ST_LEN: begin
                h_next     = h_reg + total_reg;
                idx_next   = 2'd0;
                state_next = (pend_cnt_reg != 2'd0) ? ST_TW1 : after_words;
            end
            ST_TW1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    t_next      = rotl64(mul_p, 31);
                    state_next  = ST_TW2;
                end
            end
            ST_TW2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_p;
                    state_next  = ST_TW3;
                end
            end
            ST_TW3: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p + PRIME4;
                    idx_next    = idx_reg + 2'd1;
                    state_next  = ((idx_reg + 2'd1) == pend_cnt_reg) ? after_words : ST_TW1;
                end
            end
            ST_H1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_p;
                    state_next  = ST_H2;
                end
            end
            ST_H2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p + PRIME3;
                    part_next   = part_reg >> 32;
                    nbytes_next = nbytes_reg - 3'd4;
                    state_next  = after_half;
                end
            end
            ST_B1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = h_reg ^ mul_p;
                    state_next  = ST_B2;
                end
            end
            ST_B2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p;
                    part_next   = part_reg >> 8;
                    nbytes_next = nbytes_reg - 3'd1;
                    state_next  = (nbytes_reg == 3'd1) ? ST_AV1 : ST_B1;
                end
            end
            ST_AV1: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p;
                    state_next  = ST_AV2;
                end
            end
            ST_AV2: begin
                if (mul_done) begin
                    issued_next = 1'b0;
                    h_next      = mul_p;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    hash_next     = h_reg ^ (h_reg >> 32);
                    m_valid_next  = 1'b1;
                    pend_cnt_next = 2'd0;
                    total_next    = '0;
                    stripe_next   = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next  = ST_IDLE;
                issued_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            issued_reg   <= 1'b0;
            idx_reg      <= 2'd0;
            pend_cnt_reg <= 2'd0;
            total_reg    <= '0;
            stripe_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            last_reg     <= 1'b0;
            seed_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            issued_reg   <= issued_next;
            idx_reg      <= idx_next;
            pend_cnt_reg <= pend_cnt_next;
            total_reg    <= total_next;
            stripe_reg   <= stripe_next;
            m_valid_reg  <= m_valid_next;
            last_reg     <= last_next;
            if (cfg_valid && cfg_ready) begin
                seed_reg <= cfg_seed;
            end
        end
    end

    always_ff @(posedge aclk) begin
        lane_reg   <= lane_next;
        pend_reg   <= pend_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        t_reg      <= t_next;
        part_reg   <= part_next;
        nbytes_reg <= nbytes_next;
        hash_reg   <= hash_next;
    end

endmodule

`default_nettype wire

### design/xxh_mul.sv
// 64x64 low-half multiplier built from one shared 32x32 multiplier used in turn for each partial product
`timescale 1ns / 1ps
`default_nettype none

module xxh_mul (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire xxh_pkg::word_t a,
    input  wire xxh_pkg::word_t b,
    output logic               done,
    output xxh_pkg::word_t     product
);
    import xxh_pkg::*;

    logic        busy_reg, busy_next;
    logic [1:0]  phase_reg, phase_next;
    logic        done_reg, done_next;
    word_t       a_reg, b_reg;
    word_t       prod_reg;
    word_t       acc_reg, acc_next;
    logic [31:0] op_x, op_y;
    logic [63:0] mul_full;

    // phase 0: al*bl, phase 1: ah*bl, phase 2: al*bh
    assign op_x     = (phase_reg == 2'd1) ? a_reg[63:32] : a_reg[31:0];
    assign op_y     = (phase_reg == 2'd2) ? b_reg[63:32] : b_reg[31:0];
    assign mul_full = op_x * op_y;

    always_comb begin
        busy_next  = busy_reg;
        phase_next = phase_reg;
        done_next  = 1'b0;
        acc_next   = acc_reg;
        if (busy_reg) begin
            phase_next = phase_reg + 2'd1;
            case (phase_reg)
                2'd0: acc_next = acc_reg;
                2'd1: acc_next = prod_reg;
                2'd2: acc_next = acc_reg + {prod_reg[31:0], 32'b0};
                default: begin
                    acc_next  = acc_reg + {prod_reg[31:0], 32'b0};
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            endcase
        end else if (start) begin
            busy_next  = 1'b1;
            phase_next = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end else begin
            busy_reg  <= busy_next;
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!busy_reg && start) begin
            a_reg <= a;
            b_reg <= b;
        end
        prod_reg <= mul_full;
        acc_reg  <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire
